// ----- rtl/cdgt_pkg.sv -----
// Shared types, constants and helpers for the chunk download gap tracker.
// No dependencies.
`timescale 1ns / 1ps

package cdgt_pkg;

    localparam int MAX_PACKETS = 16384;
    localparam int IDX_W       = $clog2(MAX_PACKETS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ROW_W       = 64;
    localparam int BIT_W       = $clog2(ROW_W);
    localparam int ROWS        = MAX_PACKETS / ROW_W;
    localparam int ROW_AW      = $clog2(ROWS);
    localparam int QDEPTH      = 2;
    localparam int MAXOUT      = 64;

    localparam logic [31:0] OPEN_LENGTH     = 32'hFFFF_FFFF;
    localparam logic [7:0]  RST_PACKET_SIZE = 8'd90;
    localparam logic [6:0]  RST_MAX_REQ     = 7'd20;
    localparam logic [7:0]  RST_OWN_ID      = 8'd1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_REQ = 2'd0,
        KIND_FIN = 2'd1,
        KIND_OVF = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_PACKET_SIZE = 2'd0,
        CFG_MAX_REQ     = 2'd1,
        CFG_OWN_ID      = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_OVF,
        B_DRD,
        B_DUPD,
        B_TFETCH,
        B_TLOAD,
        B_TSCAN,
        B_TFINAL
    } t_bstate;

    typedef struct packed {
        logic [7:0] packet_size;
        logic [6:0] max_requests;
        logic [7:0] own_id;
    } t_cfg;

    typedef struct packed {
        t_mode              op;
        logic [31:0]        ofs;
        logic [7:0]         cnt;
        logic [IDX_W-1:0]   idx;
        logic               ovf;
        logic [15:0]        log;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] req_log;
        logic [31:0] req_offset;
        logic [31:0] req_length;
        logic [31:0] total_bytes;
        logic        last;
    } t_res;

    function automatic logic [7:0] f_psize(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [6:0] f_limit(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) r = 7'd1;
        else if (v > 7'(MAXOUT)) r = 7'(MAXOUT);
        return r;
    endfunction

endpackage

// ----- rtl/cdgt_ifs.sv -----
// Handshake channel interfaces: input items, result items, register writes.
// No dependencies.
`timescale 1ns / 1ps

interface cdgt_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  source_id;
    logic [31:0] byte_offset;
    logic [7:0]  byte_count;
    logic [15:0] log_number;
    modport source(output valid, mode, source_id, byte_offset, byte_count, log_number,
                   input ready);
    modport sink(input valid, mode, source_id, byte_offset, byte_count, log_number,
                 output ready);
endinterface

interface cdgt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] req_log;
    logic [31:0] req_offset;
    logic [31:0] req_length;
    logic [31:0] total_bytes;
    logic        last;
    modport source(output valid, kind, req_log, req_offset, req_length, total_bytes, last,
                   input ready);
    modport sink(input valid, kind, req_log, req_offset, req_length, total_bytes, last,
                 output ready);
endinterface

interface cdgt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/cdgt_front.sv -----
// Front end: accepts items, filters sources, divides offset by packet size.
// Depends on cdgt_pkg and cdgt_ifs.
`timescale 1ns / 1ps

module cdgt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cdgt_item_if.sink      i_item,
    input  cdgt_pkg::t_cfg i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output cdgt_pkg::t_cmd o_cmd
);
    import cdgt_pkg::*;

    t_fstate     r_state, n_state;
    t_cmd        r_cmd;
    logic [7:0]  r_rem;
    logic [31:0] r_q;
    logic [4:0]  r_step;
    logic [7:0]  psz;
    logic [8:0]  trial;
    logic        qbit;
    logic [7:0]  rem_next;
    logic [31:0] q_next;
    logic        acc;

    assign psz      = f_psize(i_cfg.packet_size);
    assign trial    = {r_rem, r_q[31]};
    assign qbit     = (trial >= {1'b0, psz});
    assign rem_next = qbit ? 8'(trial - {1'b0, psz}) : trial[7:0];
    assign q_next   = {r_q[30:0], qbit};
    assign acc      = i_item.valid && i_item.ready;

    assign i_item.ready = (r_state == F_IDLE);
    assign o_push       = (r_state == F_PUSH) && !i_full;
    assign o_cmd        = r_cmd;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (acc) begin
                    if (i_item.mode == MODE_DATA) begin
                        if (i_item.source_id == i_cfg.own_id) n_state = F_DIV;
                    end else if (i_item.mode == MODE_START || i_item.mode == MODE_TICK) begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                if (r_step == 5'd31) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && acc) begin
            r_cmd.op  <= t_mode'(i_item.mode);
            r_cmd.ofs <= i_item.byte_offset;
            r_cmd.cnt <= i_item.byte_count;
            r_cmd.log <= i_item.log_number;
            r_cmd.idx <= '0;
            r_cmd.ovf <= 1'b0;
            r_q       <= i_item.byte_offset;
            r_rem     <= '0;
            r_step    <= '0;
        end else if (r_state == F_DIV) begin
            r_q    <= q_next;
            r_rem  <= rem_next;
            r_step <= r_step + 5'd1;
            if (r_step == 5'd31) begin
                r_cmd.idx <= q_next[IDX_W-1:0];
                r_cmd.ovf <= (q_next >= 32'(MAX_PACKETS));
            end
        end
    end

endmodule

// ----- rtl/cdgt_queue.sv -----
// Short command queue between front end and back end.
// Depends on cdgt_pkg.
`timescale 1ns / 1ps

module cdgt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cdgt_pkg::t_cmd i_data,
    input  logic           i_pop,
    output cdgt_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);
    import cdgt_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_cmd          r_ent [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (PW+1)'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_data;
    end

endmodule

// ----- rtl/cdgt_back.sv -----
// Back end: packet bitmap memory, download state, gap scan, result register.
// Depends on cdgt_pkg and cdgt_ifs.
`timescale 1ns / 1ps

module cdgt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cdgt_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  cdgt_pkg::t_cmd i_cmd,
    output logic           o_pop,
    cdgt_res_if.source     o_result
);
    import cdgt_pkg::*;

    t_bstate            r_state, n_state;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_hi;
    logic [CNT_W-1:0]   r_dist;
    logic [31:0]        r_ext;
    logic               r_act;
    logic [15:0]        r_log;
    logic [ROWS-1:0]    r_rowv;
    logic [ROW_W-1:0]   r_mem [ROWS];
    logic [ROW_W-1:0]   r_rdata;
    logic               r_rv;
    logic [ROW_W-1:0]   r_word;
    logic [IDX_W-1:0]   r_i;
    logic [6:0]         r_n;
    logic               r_inrun;
    logic [IDX_W-1:0]   r_start;
    logic               r_pv;
    logic [IDX_W-1:0]   r_pstart;
    logic [IDX_W-1:0]   r_plen;
    t_res               r_out;
    logic               r_ov;

    logic [7:0]         psz;
    logic [6:0]         lim;
    logic               can_emit;
    logic [ROW_AW-1:0]  rd_addr;
    logic [ROW_AW-1:0]  row;
    logic               bit_old;
    logic               mark;
    logic [CNT_W-1:0]   dist_new;
    logic [IDX_W-1:0]   hi_new;
    logic [32:0]        end_sum;
    logic [31:0]        end_sat;
    logic [31:0]        ext_new;
    logic               fin;
    logic               at_end;
    logic               sbit;
    logic               close;
    logic [6:0]         n_inc;
    logic [IDX_W-1:0]   i_inc;
    logic [31:0]        p_off, p_len, open_off;
    logic               e_valid;
    t_res               e_res;
    logic               do_begin;

    assign psz      = f_psize(i_cfg.packet_size);
    assign lim      = f_limit(i_cfg.max_requests);
    assign can_emit = !r_ov || o_result.ready;
    assign row      = r_cmd.idx[IDX_W-1:BIT_W];
    assign rd_addr  = (r_state == B_TFETCH) ? r_i[IDX_W-1:BIT_W] : row;

    assign bit_old  = r_rv && r_rdata[r_cmd.idx[BIT_W-1:0]];
    assign mark     = (r_cmd.cnt != 8'd0);
    assign dist_new = r_dist + CNT_W'(mark && !bit_old);
    assign hi_new   = (mark && r_cmd.idx > r_hi) ? r_cmd.idx : r_hi;
    assign end_sum  = {1'b0, r_cmd.ofs} + {25'b0, r_cmd.cnt};
    assign end_sat  = end_sum[32] ? OPEN_LENGTH : end_sum[31:0];
    assign ext_new  = (mark && end_sat > r_ext) ? end_sat : r_ext;
    assign fin      = !mark ||
                      (r_cmd.cnt < psz && dist_new == ({1'b0, r_cmd.idx} + CNT_W'(1)));

    assign at_end   = (r_i >= r_hi);
    assign sbit     = r_word[r_i[BIT_W-1:0]];
    assign close    = r_inrun && (at_end || sbit);
    assign n_inc    = r_n + 7'd1;
    assign i_inc    = r_i + IDX_W'(1);

    assign p_off    = 32'({18'b0, r_pstart} * {24'b0, psz});
    assign p_len    = 32'({18'b0, r_plen} * {24'b0, psz});
    assign open_off = 32'(({18'b0, r_hi} + 32'd1) * {24'b0, psz});

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    // next state and result strobe
    always_comb begin
        n_state  = r_state;
        e_valid  = 1'b0;
        do_begin = 1'b0;
        e_res    = '{kind: KIND_REQ, req_log: r_log, req_offset: 32'd0,
                     req_length: {24'b0, psz}, total_bytes: 32'd0, last: 1'b1};
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        MODE_START: n_state = B_START;
                        MODE_DATA: begin
                            if (r_act) begin
                                if (i_cmd.cnt != 8'd0 && i_cmd.ovf) n_state = B_OVF;
                                else                                n_state = B_DRD;
                            end
                        end
                        MODE_TICK: begin
                            if (r_act && r_dist != '0) n_state = B_TFETCH;
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_START: begin
                if (can_emit) begin
                    e_valid       = 1'b1;
                    do_begin      = 1'b1;
                    e_res.req_log = r_cmd.log;
                    n_state       = B_IDLE;
                end
            end
            B_OVF: begin
                if (can_emit) begin
                    e_valid          = 1'b1;
                    e_res.kind       = KIND_OVF;
                    e_res.req_offset = r_cmd.ofs;
                    e_res.req_length = 32'd0;
                    n_state          = B_IDLE;
                end
            end
            B_DRD: n_state = B_DUPD;
            B_DUPD: begin
                if (can_emit) begin
                    n_state = B_IDLE;
                    if (fin) begin
                        e_valid = 1'b1;
                        if (ext_new == 32'd0) begin
                            do_begin = 1'b1;
                        end else begin
                            e_res.kind        = KIND_FIN;
                            e_res.req_length  = 32'd0;
                            e_res.total_bytes = ext_new;
                        end
                    end
                end
            end
            B_TFETCH: n_state = B_TLOAD;
            B_TLOAD:  n_state = B_TSCAN;
            B_TSCAN: begin
                if (can_emit) begin
                    if (close) begin
                        if (r_pv) begin
                            e_valid          = 1'b1;
                            e_res.req_offset = p_off;
                            e_res.req_length = p_len;
                            e_res.last       = 1'b0;
                        end
                        if (n_inc == lim || at_end)        n_state = B_TFINAL;
                        else if (i_inc[BIT_W-1:0] == '0)   n_state = B_TFETCH;
                    end else if (at_end) begin
                        n_state = B_TFINAL;
                    end else if (i_inc[BIT_W-1:0] == '0) begin
                        n_state = B_TFETCH;
                    end
                end
            end
            B_TFINAL: begin
                if (can_emit) begin
                    e_valid = 1'b1;
                    n_state = B_IDLE;
                    if (r_pv) begin
                        e_res.req_offset = p_off;
                        e_res.req_length = p_len;
                    end else begin
                        e_res.req_offset = open_off;
                        e_res.req_length = OPEN_LENGTH;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    // download state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi   <= '0;
            r_dist <= '0;
            r_ext  <= '0;
            r_act  <= 1'b0;
            r_log  <= '0;
            r_rowv <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (do_begin) begin
                r_rowv <= '0;
                r_hi   <= '0;
                r_dist <= '0;
                r_ext  <= '0;
                r_act  <= 1'b1;
            end else if (r_state == B_DUPD && can_emit) begin
                if (mark) r_rowv[row] <= 1'b1;
                r_hi   <= hi_new;
                r_dist <= dist_new;
                r_ext  <= ext_new;
                if (fin) r_act <= 1'b0;
            end
            if (r_state == B_START && can_emit) r_log <= r_cmd.log;
            if (e_valid)              r_ov <= 1'b1;
            else if (o_result.ready)  r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid) r_out <= e_res;
        if (o_pop) r_cmd <= i_cmd;
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        r_rv    <= r_rowv[rd_addr];
        if (r_state == B_DUPD && can_emit && mark) begin
            r_mem[row] <= (r_rv ? r_rdata : '0) | (ROW_W'(1) << r_cmd.idx[BIT_W-1:0]);
        end
    end

    // gap scan
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE) begin
            r_i     <= '0;
            r_n     <= '0;
            r_inrun <= 1'b0;
            r_pv    <= 1'b0;
        end else if (r_state == B_TLOAD) begin
            r_word <= r_rv ? r_rdata : '0;
        end else if (r_state == B_TSCAN && can_emit) begin
            if (close) begin
                r_pv     <= 1'b1;
                r_pstart <= r_start;
                r_plen   <= r_i - r_start;
                r_n      <= n_inc;
                r_inrun  <= 1'b0;
                if (!(n_inc == lim || at_end)) r_i <= i_inc;
            end else if (!at_end) begin
                if (!sbit && !r_inrun) begin
                    r_inrun <= 1'b1;
                    r_start <= r_i;
                end
                r_i <= i_inc;
            end
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.kind        = r_out.kind;
    assign o_result.req_log     = r_out.req_log;
    assign o_result.req_offset  = r_out.req_offset;
    assign o_result.req_length  = r_out.req_length;
    assign o_result.total_bytes = r_out.total_bytes;
    assign o_result.last        = r_out.last;

endmodule

// ----- rtl/chunk_download_gap_tracker.sv -----
// Top level: configuration registers, front end, command queue, back end.
// Depends on cdgt_pkg, cdgt_ifs, cdgt_front, cdgt_queue, cdgt_back.
// Data item: accepted only while the front end is idle, its offset divided by the packet
// size there, then read and updated in the back end. Start item: passed through to the back
// end. Tick: scans the bitmap bits up to the highest packet, fetching each 64-bit row.
// Synchronous active-low reset; bitmap rows are invalidated at once, no sweep.
`timescale 1ns / 1ps

module chunk_download_gap_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdgt_item_if.sink  i_item,
    cdgt_res_if.source o_result,
    cdgt_cfg_if.sink   i_cfg
);
    import cdgt_pkg::*;

    t_cfg r_cfg;
    t_cmd f_cmd, q_cmd;
    logic q_push, q_pop, q_full, q_empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.packet_size  <= RST_PACKET_SIZE;
            r_cfg.max_requests <= RST_MAX_REQ;
            r_cfg.own_id       <= RST_OWN_ID;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PACKET_SIZE: r_cfg.packet_size  <= i_cfg.data;
                CFG_MAX_REQ:     r_cfg.max_requests <= i_cfg.data[6:0];
                CFG_OWN_ID:      r_cfg.own_id       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    cdgt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    cdgt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cdgt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_cmd    (q_cmd),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("queue pop while empty");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.kind == KIND_OVF) |-> o_result.last)
        else $error("overflow result not last");

    a_fin_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.kind == KIND_FIN) |-> (o_result.total_bytes != 32'd0))
        else $error("finish with zero extent");

endmodule
